// File: hdl/pg_simple_query_framer_macros.svh
// ---------------------------------------------------------------------------
// pg_simple_query_framer_macros.svh
// Assertion helpers shared by the framer checker.
// ---------------------------------------------------------------------------
`ifndef PG_SIMPLE_QUERY_FRAMER_MACROS_SVH
`define PG_SIMPLE_QUERY_FRAMER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PGSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pgsq assertion failed");

// next-cycle implication, disabled while in reset
`define PGSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pgsq assertion failed");

`endif

// File: hdl/pgsq_pkg.sv
// ---------------------------------------------------------------------------
// pgsq_pkg
// Types and constants of the simple-query framer.
// ---------------------------------------------------------------------------
package pgsq_pkg;

	localparam int PREAMBLE_BYTES_DEF = 8;
	localparam int LEN_BYTES          = 4;   // bytes of a length field
	localparam int MIN_LEN            = 4;   // shorter lengths are clamped to this
	localparam logic [7:0] QUERY_TYPE = 8'h51;  // 'Q'

	typedef struct packed {
		logic       valid;
		logic [7:0] query_byte;
		logic       last_of_query;
		logic       empty_query;
	} result_t;

endpackage

// File: hdl/pgsq_core.sv
// ---------------------------------------------------------------------------
// pgsq_core
// Framing state machine: preamble skip, message type, length and payload.
// ---------------------------------------------------------------------------
module pgsq_core #(
	parameter int PREAMBLE_BYTES = pgsq_pkg::PREAMBLE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        data_byte,
	output pgsq_pkg::result_t res
);

	localparam int CW = (PREAMBLE_BYTES > pgsq_pkg::LEN_BYTES) ?
		$clog2(PREAMBLE_BYTES + 1) : $clog2(pgsq_pkg::LEN_BYTES + 1);

	typedef enum logic [2:0] {
		PH_PRE_HEAD = 3'd0,
		PH_PRE_LEN  = 3'd1,
		PH_PRE_SKIP = 3'd2,
		PH_TYPE     = 3'd3,
		PH_LEN      = 3'd4,
		PH_PAYLOAD  = 3'd5
	} phase_t;

	localparam phase_t PH_RESET = (PREAMBLE_BYTES == 0) ? PH_PRE_LEN : PH_PRE_HEAD;

	phase_t        phase_q, phase_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
	logic [31:0]   len_q, len_d, len_shift, len_clamp, len_rem, len_dec;
	logic          is_query_q, is_query_d;

	always_comb begin
		cnt_inc   = cnt_q + CW'(1);
		len_shift = {len_q[23:0], data_byte};
		len_clamp = (len_shift < 32'(pgsq_pkg::MIN_LEN)) ? 32'(pgsq_pkg::MIN_LEN) : len_shift;
		len_rem   = len_clamp - 32'(pgsq_pkg::LEN_BYTES);
		len_dec   = len_q - 32'd1;
	end

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		len_d      = len_q;
		is_query_d = is_query_q;
		res        = '0;
		unique case (phase_q)
			PH_PRE_HEAD: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= CW'(PREAMBLE_BYTES)) begin
					cnt_d   = '0;
					len_d   = '0;
					phase_d = PH_PRE_LEN;
				end
			end
			PH_PRE_LEN: begin
				len_d = len_shift;
				cnt_d = cnt_inc;
				if (cnt_inc >= CW'(pgsq_pkg::LEN_BYTES)) begin
					cnt_d   = '0;
					len_d   = len_rem;
					phase_d = (len_rem == 32'd0) ? PH_TYPE : PH_PRE_SKIP;
				end
			end
			PH_PRE_SKIP: begin
				len_d = len_dec;
				if (len_dec == 32'd0) phase_d = PH_TYPE;
			end
			PH_LEN: begin
				len_d = len_shift;
				cnt_d = cnt_inc;
				if (cnt_inc >= CW'(pgsq_pkg::LEN_BYTES)) begin
					cnt_d   = '0;
					len_d   = len_rem;
					phase_d = (len_rem == 32'd0) ? PH_TYPE : PH_PAYLOAD;
					// no text: a lone payload byte is only the terminator
					if (is_query_q && len_rem <= 32'd1) begin
						res.valid         = 1'b1;
						res.last_of_query = 1'b1;
						res.empty_query   = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				len_d = len_dec;
				if (len_dec == 32'd0) phase_d = PH_TYPE;
				if (is_query_q && len_q >= 32'd2) begin
					res.valid         = 1'b1;
					res.query_byte    = data_byte;
					res.last_of_query = (len_q == 32'd2);
				end
			end
			default: begin  // type byte; unused codes behave the same
				is_query_d = (data_byte == pgsq_pkg::QUERY_TYPE);
				cnt_d      = '0;
				len_d      = '0;
				phase_d    = PH_LEN;
			end
		endcase
		res.valid = res.valid & fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RESET;
			cnt_q      <= '0;
			len_q      <= '0;
			is_query_q <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			len_q      <= len_d;
			is_query_q <= is_query_d;
		end
	end

endmodule

// File: hdl/pgsq_out_reg.sv
// ---------------------------------------------------------------------------
// pgsq_out_reg
// Result register on the master side; holds a result until taken.
// ---------------------------------------------------------------------------
module pgsq_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pgsq_pkg::result_t res,
	output logic              m_tvalid,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	logic       valid_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			data_q  <= res.query_byte;
			last_q  <= res.last_of_query;
			empty_q <= res.empty_query;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = empty_q;

endmodule

// File: hdl/pg_simple_query_framer.sv
// ---------------------------------------------------------------------------
// pg_simple_query_framer
// Extracts simple-query text from a client wire byte stream.
//
// channel  dir  payload                          accept
// s_*      in   tdata[7:0] data_byte             s_tvalid & s_tready
// m_*      out  tdata[7:0] query_byte,           m_tvalid & m_tready
//               tlast last_of_query, tuser empty_query
//
// One byte per cycle sustained while the master side takes results; a byte
// passes the input register, then its result is held in the result register.
// The framing counters and the 32-bit remaining length update together, on each advance.
// arst_n clears the phase, counters and both valid flags.
// A stalled master side holds the result; input stalls only once the input
// register and the result register are both full.
// ---------------------------------------------------------------------------
module pg_simple_query_framer #(
	parameter int PREAMBLE_BYTES = pgsq_pkg::PREAMBLE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] query_byte
	output logic       m_tlast,   // last_of_query
	output logic       m_tuser    // empty_query
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              out_free;
	logic              advance;
	pgsq_pkg::result_t res;

	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) data_s1 <= s_tdata;
	end

	pgsq_core #(
		.PREAMBLE_BYTES(PREAMBLE_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.data_byte(data_s1),
		.res      (res)
	);

	pgsq_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (out_free),
		.res     (res),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

// File: hdl/pgsq_checker.sv
// ---------------------------------------------------------------------------
// pgsq_checker
// Port-level checks of the simple-query framer, bound to the top level.
// ---------------------------------------------------------------------------
`include "pg_simple_query_framer_macros.svh"

module pgsq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	`PGSQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`PGSQ_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`PGSQ_ASSERT_IMPL(a_empty_last, clk, arst_n, m_tvalid && m_tuser, m_tlast && m_tdata == 8'd0)
	// input only backs up behind a full result register
	`PGSQ_ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind pg_simple_query_framer pgsq_checker u_pgsq_checker (.*);
